@@ rtl/sspq_pkg.sv @@
package sspq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 5;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

@@ rtl/sspq_req_if.sv @@
interface sspq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic signed [sspq_pkg::DATA_W-1:0]    data_in;
  logic [sspq_pkg::PRIO_W-1:0]           priority_in;

  modport source (output valid, output command, output data_in, output priority_in,
                  input ready);
  modport sink (input valid, input command, input data_in, input priority_in,
                output ready);
endinterface

@@ rtl/sspq_rsp_if.sv @@
interface sspq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sspq_pkg::DATA_W-1:0]    data_out;
  logic [1:0]                            status;
  logic [sspq_pkg::OUT_CNT_W-1:0]        entry_count;

  modport source (output valid, output data_out, output status, output entry_count,
                  input ready);
  modport sink (input valid, input data_out, input status, input entry_count,
                output ready);
endinterface

@@ rtl/sspq_cell.sv @@
module sspq_cell (
  input  logic                 clk,
  input  sspq_pkg::cell_ctrl_t ctrl,
  input  sspq_pkg::entry_t     new_entry,
  input  logic                 occupied,
  input  logic                 keep_prev,
  input  sspq_pkg::entry_t     prev_entry,
  input  sspq_pkg::entry_t     next_entry,
  output sspq_pkg::entry_t     entry,
  output logic                 keep
);
  import sspq_pkg::*;

  entry_t entry_next;

  // an occupied cell at or below the new priority holds its place
  assign keep = occupied && (entry.prio <= new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.enq && !keep) begin
      if (keep_prev) begin
        entry_next = new_entry;
      end else begin
        entry_next = prev_entry;
      end
    end else if (ctrl.deq) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ rtl/stable_sorted_priority_queue.sv @@
// Sorted priority queue of DEPTH entries, held in a row of cells.
// req channel: command (0 enqueue, 1 dequeue), data_in, priority_in.
// rsp channel: data_out, status, entry_count; exactly one rsp transaction
// follows each req transaction, in order.
// An enqueue lands behind every held entry of lower or equal priority
// number, so equal numbers leave in arrival order. A dequeue returns the
// front entry. Enqueue on a full queue is dropped (status 3); dequeue on
// an empty queue returns status 2 with data_out zero.
// Latency: the result is valid the cycle after the request is taken.
// Throughput: one request per cycle while req.ready is high; every cell
// compares and shifts in the same cycle, so the row depth does not affect the rate.
// The single output register stalls req.ready while a result waits and
// rsp.ready is low; nothing is lost or repeated.
// Reset (rst, synchronous) empties the queue and clears the output valid; no
// clearing pass is needed, so requests are taken the cycle after reset.
module stable_sorted_priority_queue (
  input logic       clk,
  input logic       rst,
  sspq_req_if.sink  req,
  sspq_rsp_if.source rsp
);
  import sspq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_valid;
  logic signed [DATA_W-1:0] out_data;
  logic [1:0]       out_status;

  logic             take;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           cells [DEPTH];
  logic [DEPTH-1:0] keep;
  logic [DEPTH-1:0] occupied;

  assign take  = req.valid && req.ready;
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign req.ready = !out_valid || rsp.ready;

  assign ctrl.enq = take && (req.command == CMD_ENQUEUE) && !full;
  assign ctrl.deq = take && (req.command == CMD_DEQUEUE) && !empty;
  assign new_entry.data = req.data_in;
  assign new_entry.prio = req.priority_in;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;
      logic   keep_p;

      assign occupied[i] = (count > CNT_W'(i));

      if (i == 0) begin : g_first
        assign prev_e = new_entry;
        assign keep_p = 1'b1;
      end else begin : g_mid
        assign prev_e = cells[i-1];
        assign keep_p = keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign next_e = cells[i];
      end else begin : g_inner
        assign next_e = cells[i+1];
      end

      sspq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .occupied   (occupied[i]),
        .keep_prev  (keep_p),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .entry      (cells[i]),
        .keep       (keep[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      case (req.command)
        CMD_ENQUEUE: begin
          out_data   <= '0;
          out_status <= full ? ST_FULL : ST_ENQUEUED;
        end
        CMD_DEQUEUE: begin
          if (empty) begin
            out_data   <= '0;
            out_status <= ST_EMPTY;
          end else begin
            out_status <= ST_DEQUEUED;
            out_data   <= cells[0].data;
          end
        end
        default: begin
          out_data   <= '0;
          out_status <= ST_EMPTY;
        end
      endcase
    end
  end

  // count already holds the post-transaction value when the result is shown
  assign rsp.valid       = out_valid;
  assign rsp.data_out    = out_data;
  assign rsp.status      = out_status;
  assign rsp.entry_count = OUT_CNT_W'(count);

endmodule
